// File: hdl/momentum_observer_collision_isolate_core_assert.svh
// Assertion macros for the momentum observer core.
// Used by the top level only; no other dependencies.
`ifndef MOMENTUM_OBSERVER_COLLISION_ISOLATE_CORE_ASSERT_SVH
`define MOMENTUM_OBSERVER_COLLISION_ISOLATE_CORE_ASSERT_SVH

// same-cycle implication
`define MOCOL_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");

// next-cycle implication
`define MOCOL_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication failed");

`endif

// File: hdl/mocol_pkg.sv
// Shared types, constants and helper functions for the momentum observer core.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package mocol_pkg;

   localparam int JOINTS      = 4;
   localparam int JW          = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam int DATA_W      = 32;
   localparam int STEP_W      = 24;
   localparam int GAIN_W      = 32;
   localparam int THR_W       = 31;
   localparam int SUM_W       = 34;
   localparam int DIFF_W      = 33;
   localparam int MA_W        = 18;
   localparam int MB_W        = 33;
   localparam int PROD_W      = MA_W + MB_W;
   localparam int ACC_W       = 66;
   localparam int CONTACT_W   = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int STEP_SHIFT  = 24;
   localparam int GAIN_SHIFT  = 16;
   localparam int SUM_SPLIT   = 17;
   localparam int DIFF_SPLIT  = 16;

   localparam logic [STEP_W-1:0] STEP_TIME_RST = 24'd16777;
   localparam logic [GAIN_W-1:0] GAIN_RST      = 32'd6553600;
   localparam logic [THR_W-1:0]  THR_RST       = 31'd98304;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_TIME         = 2'd0,
      CSR_OBSERVER_GAIN     = 2'd1,
      CSR_CONTACT_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_NONE    = 4'd0,
      OP_CAPTURE = 4'd1,
      OP_SUM     = 4'd2,
      OP_MLO     = 4'd3,
      OP_MHI     = 4'd4,
      OP_IACC    = 4'd5,
      OP_INTEG   = 4'd6,
      OP_DIFF    = 4'd7,
      OP_GLO     = 4'd8,
      OP_GHI     = 4'd9,
      OP_GACC    = 4'd10,
      OP_RES     = 4'd11,
      OP_OUT     = 4'd12
   } dp_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic [JW-1:0]     joint;
   } dp_cmd_type;

   typedef logic [JOINTS-1:0][DATA_W-1:0] joint_vec_type;

   // clamp a wide signed value to the signed 32-bit range
   function automatic logic [DATA_W-1:0] sat_s32(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-DATA_W:0] top;
      top = v[ACC_W-1:DATA_W-1];
      if ((&top) || !(|top)) begin
         return v[DATA_W-1:0];
      end else if (v[ACC_W-1]) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end
   endfunction

   // highest flagged joint counted from one, zero when none
   function automatic logic [CONTACT_W-1:0] contact_of(input logic [JOINTS-1:0] mask);
      logic [CONTACT_W-1:0] c;
      c = '0;
      for (int i = 0; i < JOINTS; i++) begin
         if (mask[i]) begin
            c = CONTACT_W'(i + 1);
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: hdl/mocol_ctrl.sv
// Sequencer for the momentum observer: steps each joint through the shared
// multiplier and owns the request and result handshakes. Depends on mocol_pkg.
`default_nettype none

module mocol_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output mocol_pkg::dp_cmd_type cmd
);
   import mocol_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b0000_0000_0001,
      ST_SUM   = 12'b0000_0000_0010,
      ST_MLO   = 12'b0000_0000_0100,
      ST_MHI   = 12'b0000_0000_1000,
      ST_IACC  = 12'b0000_0001_0000,
      ST_INTEG = 12'b0000_0010_0000,
      ST_DIFF  = 12'b0000_0100_0000,
      ST_GLO   = 12'b0000_1000_0000,
      ST_GHI   = 12'b0001_0000_0000,
      ST_GACC  = 12'b0010_0000_0000,
      ST_RES   = 12'b0100_0000_0000,
      ST_DONE  = 12'b1000_0000_0000
   } state_type;

   state_type     state_ff, state_in;
   logic [JW-1:0] joint_ff, joint_in;
   logic          rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      joint_in     = joint_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = OP_NONE;
      cmd.joint    = joint_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               joint_in = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.op   = OP_SUM;
            state_in = ST_MLO;
         end
         ST_MLO: begin
            cmd.op   = OP_MLO;
            state_in = ST_MHI;
         end
         ST_MHI: begin
            cmd.op   = OP_MHI;
            state_in = ST_IACC;
         end
         ST_IACC: begin
            cmd.op   = OP_IACC;
            state_in = ST_INTEG;
         end
         ST_INTEG: begin
            cmd.op   = OP_INTEG;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = ST_GLO;
         end
         ST_GLO: begin
            cmd.op   = OP_GLO;
            state_in = ST_GHI;
         end
         ST_GHI: begin
            cmd.op   = OP_GHI;
            state_in = ST_GACC;
         end
         ST_GACC: begin
            cmd.op   = OP_GACC;
            state_in = ST_RES;
         end
         ST_RES: begin
            cmd.op = OP_RES;
            if (joint_ff == JW'(JOINTS - 1)) begin
               state_in = ST_DONE;
            end else begin
               joint_in = joint_ff + 1'b1;
               state_in = ST_SUM;
            end
         end
         ST_DONE: begin
            // hold until the previous result has gone
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         joint_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         joint_ff     <= joint_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/mocol_dpath.sv
// Datapath of the momentum observer: control registers, per-joint state, the
// shared 18x33 multiplier with accumulator, and the result registers. Depends on mocol_pkg.
`default_nettype none

module mocol_dpath (
   input  wire                             clock,
   input  wire                             reset,
   input  mocol_pkg::dp_cmd_type           cmd,
   input  wire                             csr_we,
   input  wire [mocol_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [mocol_pkg::DATA_W-1:0]     csr_data,
   input  mocol_pkg::joint_vec_type        req_momentum,
   input  mocol_pkg::joint_vec_type        req_drive_torque,
   input  mocol_pkg::joint_vec_type        req_gravity_torque,
   output mocol_pkg::joint_vec_type        rsp_residual,
   output logic [mocol_pkg::JOINTS-1:0]    rsp_over_mask,
   output logic [mocol_pkg::CONTACT_W-1:0] rsp_contact_joint
);
   import mocol_pkg::*;

   logic [STEP_W-1:0]         step_ff;
   logic [GAIN_W-1:0]         gain_ff;
   logic [THR_W-1:0]          thr_ff;

   joint_vec_type             mom_ff, mom_in;
   joint_vec_type             tau_ff, tau_in;
   joint_vec_type             grav_ff, grav_in;
   joint_vec_type             integ_ff, integ_in;
   joint_vec_type             last_res_ff, last_res_in;
   logic [JOINTS-1:0]         mask_ff, mask_in;

   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;

   joint_vec_type             res_out_ff, res_out_in;
   logic [JOINTS-1:0]         mask_out_ff, mask_out_in;
   logic [CONTACT_W-1:0]      contact_ff, contact_in;

   logic signed [MA_W-1:0]    mul_a;
   logic signed [MB_W-1:0]    mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [ACC_W-1:0]   prod_ext;
   logic signed [ACC_W-1:0]   integ_sum;
   logic [DATA_W-1:0]         integ_rd;
   logic [DATA_W-1:0]         res_val;

   assign rsp_residual      = res_out_ff;
   assign rsp_over_mask     = mask_out_ff;
   assign rsp_contact_joint = contact_ff;

   assign integ_rd = integ_ff[cmd.joint];
   assign prod_ext = $signed({{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff});
   assign integ_sum = $signed({{(ACC_W-DATA_W){integ_rd[DATA_W-1]}}, integ_rd})
                      + (acc_ff >>> STEP_SHIFT);
   assign res_val   = sat_s32(acc_ff >>> GAIN_SHIFT);

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MLO: begin
            mul_a = $signed({1'b0, sum_ff[SUM_SPLIT-1:0]});
            mul_b = $signed({{(MB_W-STEP_W){1'b0}}, step_ff});
         end
         OP_MHI: begin
            mul_a = $signed({sum_ff[SUM_W-1], sum_ff[SUM_W-1:SUM_SPLIT]});
            mul_b = $signed({{(MB_W-STEP_W){1'b0}}, step_ff});
         end
         OP_GLO: begin
            mul_a = $signed({{(MA_W-DIFF_SPLIT){1'b0}}, diff_ff[DIFF_SPLIT-1:0]});
            mul_b = $signed({1'b0, gain_ff});
         end
         OP_GHI: begin
            mul_a = $signed({diff_ff[DIFF_W-1], diff_ff[DIFF_W-1:DIFF_SPLIT]});
            mul_b = $signed({1'b0, gain_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      mom_in      = mom_ff;
      tau_in      = tau_ff;
      grav_in     = grav_ff;
      integ_in    = integ_ff;
      last_res_in = last_res_ff;
      mask_in     = mask_ff;
      sum_in      = sum_ff;
      diff_in     = diff_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      res_out_in  = res_out_ff;
      mask_out_in = mask_out_ff;
      contact_in  = contact_ff;
      case (cmd.op)
         OP_CAPTURE: begin
            mom_in  = req_momentum;
            tau_in  = req_drive_torque;
            grav_in = req_gravity_torque;
            mask_in = '0;
         end
         OP_SUM: begin
            sum_in = $signed({{(SUM_W-DATA_W){tau_ff[cmd.joint][DATA_W-1]}},
                              tau_ff[cmd.joint]})
                   - $signed({{(SUM_W-DATA_W){grav_ff[cmd.joint][DATA_W-1]}},
                              grav_ff[cmd.joint]})
                   + $signed({{(SUM_W-DATA_W){last_res_ff[cmd.joint][DATA_W-1]}},
                              last_res_ff[cmd.joint]});
         end
         OP_MLO, OP_GLO: begin
            prod_in = mul_p;
         end
         OP_MHI, OP_GHI: begin
            // low partial product moves to the accumulator
            prod_in = mul_p;
            acc_in  = prod_ext;
         end
         OP_IACC: begin
            acc_in = acc_ff + (prod_ext <<< SUM_SPLIT);
         end
         OP_INTEG: begin
            integ_in[cmd.joint] = sat_s32(integ_sum);
         end
         OP_DIFF: begin
            diff_in = $signed({mom_ff[cmd.joint][DATA_W-1], mom_ff[cmd.joint]})
                    - $signed({integ_rd[DATA_W-1], integ_rd});
         end
         OP_GACC: begin
            acc_in = acc_ff + (prod_ext <<< DIFF_SPLIT);
         end
         OP_RES: begin
            last_res_in[cmd.joint] = res_val;
            mask_in[cmd.joint]     = $signed(res_val) > $signed({1'b0, thr_ff});
         end
         OP_OUT: begin
            res_out_in  = last_res_ff;
            mask_out_in = mask_ff;
            contact_in  = contact_of(mask_ff);
         end
         default: begin
            mask_in = mask_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= STEP_TIME_RST;
         gain_ff     <= GAIN_RST;
         thr_ff      <= THR_RST;
         integ_ff    <= '0;
         last_res_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_STEP_TIME:         step_ff <= csr_data[STEP_W-1:0];
               CSR_OBSERVER_GAIN:     gain_ff <= csr_data[GAIN_W-1:0];
               CSR_CONTACT_THRESHOLD: thr_ff  <= csr_data[THR_W-1:0];
               default:               thr_ff  <= thr_ff;
            endcase
         end
         integ_ff    <= integ_in;
         last_res_ff <= last_res_in;
      end
   end

   always_ff @(posedge clock) begin
      mom_ff      <= mom_in;
      tau_ff      <= tau_in;
      grav_ff     <= grav_in;
      mask_ff     <= mask_in;
      sum_ff      <= sum_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      res_out_ff  <= res_out_in;
      mask_out_ff <= mask_out_in;
      contact_ff  <= contact_in;
   end

endmodule

`default_nettype wire

// File: hdl/momentum_observer_collision_isolate_core.sv
// Top level of the momentum observer with collision isolation.
// Depends on mocol_pkg, mocol_ctrl, mocol_dpath and the assertion header.
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+------------------------------------------
//  req     | req_valid / req_stall   | momentum, drive torque, gravity per joint
//  rsp     | rsp_valid / rsp_stall   | residual per joint, over_mask, contact
//  csr     | csr_valid / csr_ready   | csr_index, csr_data
//
// rsp_valid rises once each joint has passed through the single shared 18x33
// multiplier (two partial products for the integral, two for the gain) and the
// output registers have been loaded; a new request is accepted only after that.
// A result waits in its output register while the next request is accepted.
// Reset is synchronous; the integrals and residuals clear at once, no sweep.
// csr_ready is always high; write registers only while no request is in flight.
`default_nettype none

`include "momentum_observer_collision_isolate_core_assert.svh"

module momentum_observer_collision_isolate_core (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire [mocol_pkg::DATA_W-1:0]     req_momentum_0,
   input  wire [mocol_pkg::DATA_W-1:0]     req_momentum_1,
   input  wire [mocol_pkg::DATA_W-1:0]     req_momentum_2,
   input  wire [mocol_pkg::DATA_W-1:0]     req_momentum_3,
   input  wire [mocol_pkg::DATA_W-1:0]     req_drive_torque_0,
   input  wire [mocol_pkg::DATA_W-1:0]     req_drive_torque_1,
   input  wire [mocol_pkg::DATA_W-1:0]     req_drive_torque_2,
   input  wire [mocol_pkg::DATA_W-1:0]     req_drive_torque_3,
   input  wire [mocol_pkg::DATA_W-1:0]     req_gravity_torque_0,
   input  wire [mocol_pkg::DATA_W-1:0]     req_gravity_torque_1,
   input  wire [mocol_pkg::DATA_W-1:0]     req_gravity_torque_2,
   input  wire [mocol_pkg::DATA_W-1:0]     req_gravity_torque_3,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic [mocol_pkg::DATA_W-1:0]    rsp_residual_0,
   output logic [mocol_pkg::DATA_W-1:0]    rsp_residual_1,
   output logic [mocol_pkg::DATA_W-1:0]    rsp_residual_2,
   output logic [mocol_pkg::DATA_W-1:0]    rsp_residual_3,
   output logic [mocol_pkg::JOINTS-1:0]    rsp_over_mask,
   output logic [mocol_pkg::CONTACT_W-1:0] rsp_contact_joint,
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire [mocol_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [mocol_pkg::DATA_W-1:0]     csr_data
);
   import mocol_pkg::*;

   dp_cmd_type    cmd;
   joint_vec_type req_mom;
   joint_vec_type req_tau;
   joint_vec_type req_grav;
   joint_vec_type rsp_res;

   assign csr_ready = 1'b1;

   assign req_mom  = {req_momentum_3, req_momentum_2, req_momentum_1, req_momentum_0};
   assign req_tau  = {req_drive_torque_3, req_drive_torque_2,
                      req_drive_torque_1, req_drive_torque_0};
   assign req_grav = {req_gravity_torque_3, req_gravity_torque_2,
                      req_gravity_torque_1, req_gravity_torque_0};

   assign rsp_residual_0 = rsp_res[0];
   assign rsp_residual_1 = rsp_res[1];
   assign rsp_residual_2 = rsp_res[2];
   assign rsp_residual_3 = rsp_res[3];

   mocol_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   mocol_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .csr_we             (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_momentum       (req_mom),
      .req_drive_torque   (req_tau),
      .req_gravity_torque (req_grav),
      .rsp_residual       (rsp_res),
      .rsp_over_mask      (rsp_over_mask),
      .rsp_contact_joint  (rsp_contact_joint)
   );

   // an accepted request keeps the core busy in the following cycle
   `MOCOL_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // a fresh result only appears at the end of a busy stretch
   `MOCOL_ASSERT_IMPL(a_result_after_work, clock, reset, $rose(rsp_valid), $past(req_stall))
   // contact index and mask agree on whether any joint is flagged
   `MOCOL_ASSERT_IMPL(a_contact_matches_mask, clock, reset, rsp_valid,
      (rsp_over_mask == '0) == (rsp_contact_joint == '0))
   // commands reach the datapath only while a request is in progress or accepted
   `MOCOL_ASSERT_IMPL(a_cmd_only_when_busy, clock, reset, cmd.op != OP_NONE,
      req_stall || req_valid)

endmodule

`default_nettype wire

// File: tb/momentum_observer_checker.sv
`timescale 1ns / 1ps
// Checker for the momentum observer core: follows register writes, predicts the
// residuals, contact mask and contact joint of every request and compares them.
// Depends on mocol_pkg only.

module momentum_observer_checker (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   input  wire                                req_stall,
   input  mocol_pkg::joint_vec_type           req_momentum,
   input  mocol_pkg::joint_vec_type           req_drive_torque,
   input  mocol_pkg::joint_vec_type           req_gravity_torque,
   input  wire                                rsp_valid,
   input  wire                                rsp_stall,
   input  mocol_pkg::joint_vec_type           rsp_residual,
   input  wire [mocol_pkg::JOINTS-1:0]        rsp_over_mask,
   input  wire [mocol_pkg::CONTACT_W-1:0]     rsp_contact_joint,
   input  wire                                csr_valid,
   input  wire                                csr_ready,
   input  wire [mocol_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [mocol_pkg::DATA_W-1:0]        csr_data,
   output int                                 mismatches,
   output int                                 pending
);
   import mocol_pkg::*;

   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;
   localparam int PRINT_LIMIT = 100;

   typedef struct packed {
      joint_vec_type          residual;
      logic [JOINTS-1:0]      over_mask;
      logic [CONTACT_W-1:0]   contact_joint;
   } observer_result_type;

   logic [STEP_W-1:0]   step_time;
   logic [GAIN_W-1:0]   observer_gain;
   logic [THR_W-1:0]    contact_threshold;
   longint              torque_integral [JOINTS];
   longint              last_residual [JOINTS];
   observer_result_type expected_results [$];

   function automatic longint clamp_s32(input longint v);
      if (v > S32_MAX) return S32_MAX;
      if (v < S32_MIN) return S32_MIN;
      return v;
   endfunction

   // advance the observer by one tick and return what the core must report
   function automatic observer_result_type predict_residuals(input joint_vec_type p,
                                                             input joint_vec_type tau,
                                                             input joint_vec_type g);
      observer_result_type r;
      int                  pj, tj, gj;
      longint              sum, inc, diff, res, dt, thr;
      logic signed [127:0] prod, gain_w;
      r = '0;
      dt = step_time;
      thr = contact_threshold;
      gain_w = observer_gain;
      for (int j = 0; j < JOINTS; j++) begin
         pj = p[j];
         tj = tau[j];
         gj = g[j];
         sum = longint'(tj) - longint'(gj) + last_residual[j];
         // arithmetic shift floors toward minus infinity
         inc = (sum * dt) >>> STEP_SHIFT;
         torque_integral[j] = clamp_s32(torque_integral[j] + inc);
         diff = longint'(pj) - torque_integral[j];
         prod = diff;
         prod = (prod * gain_w) >>> GAIN_SHIFT;
         if (prod > 128'sd2147483647) begin
            res = S32_MAX;
         end else if (prod < -128'sd2147483648) begin
            res = S32_MIN;
         end else begin
            res = prod[63:0];
         end
         last_residual[j] = res;
         r.residual[j] = res[DATA_W-1:0];
         if (res > thr) begin
            r.over_mask[j] = 1'b1;
            r.contact_joint = CONTACT_W'(j + 1);
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                  input logic [DATA_W-1:0] got);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      observer_result_type want;
      if (reset) begin
         step_time = STEP_TIME_RST;
         observer_gain = GAIN_RST;
         contact_threshold = THR_RST;
         for (int j = 0; j < JOINTS; j++) begin
            torque_integral[j] = 0;
            last_residual[j] = 0;
         end
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_STEP_TIME:         step_time = csr_data[STEP_W-1:0];
               CSR_OBSERVER_GAIN:     observer_gain = csr_data[GAIN_W-1:0];
               CSR_CONTACT_THRESHOLD: contact_threshold = csr_data[THR_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_results.push_back(predict_residuals(req_momentum, req_drive_torque,
                                                         req_gravity_torque));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unrequested result, residual_0", '0, rsp_residual[0]);
            end else begin
               want = expected_results.pop_front();
               for (int j = 0; j < JOINTS; j++) begin
                  if (rsp_residual[j] !== want.residual[j]) begin
                     report_mismatch($sformatf("residual_%0d", j), want.residual[j],
                                     rsp_residual[j]);
                  end
               end
               if (rsp_over_mask !== want.over_mask) begin
                  report_mismatch("over_mask", DATA_W'(want.over_mask), DATA_W'(rsp_over_mask));
               end
               if (rsp_contact_joint !== want.contact_joint) begin
                  report_mismatch("contact_joint", DATA_W'(want.contact_joint),
                                  DATA_W'(rsp_contact_joint));
               end
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the momentum observer testbench: clock, reset, request and register
// stimulus, result back-pressure and the verdict.
// Depends on mocol_pkg, momentum_observer_collision_isolate_core and the checker.

module testbench;
   import mocol_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 50;
   localparam int PHASES       = 9;
   localparam int PHASE_ITEMS  = 60;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [DATA_W-1:0] Q_MAX    = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] Q_MIN    = 32'h8000_0000;
   localparam logic [DATA_W-1:0] Q_ONE    = 32'h0001_0000;
   localparam logic [DATA_W-1:0] DT_MAX   = 32'h00ff_ffff;
   localparam logic [DATA_W-1:0] THR_MAX  = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] THRESH   = 32'd1000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   wire           req_stall;
   joint_vec_type momentum = '0;
   joint_vec_type drive_torque = '0;
   joint_vec_type gravity_torque = '0;
   wire           rsp_valid;
   logic          rsp_stall = 1'b0;
   wire [DATA_W-1:0]    residual_0, residual_1, residual_2, residual_3;
   wire [JOINTS-1:0]    over_mask;
   wire [CONTACT_W-1:0] contact_joint;
   logic                 csr_valid = 1'b0;
   wire                  csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0]    csr_data = '0;

   int mismatches;
   int pending;
   int cycles = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   momentum_observer_collision_isolate_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_momentum_0       (momentum[0]),
      .req_momentum_1       (momentum[1]),
      .req_momentum_2       (momentum[2]),
      .req_momentum_3       (momentum[3]),
      .req_drive_torque_0   (drive_torque[0]),
      .req_drive_torque_1   (drive_torque[1]),
      .req_drive_torque_2   (drive_torque[2]),
      .req_drive_torque_3   (drive_torque[3]),
      .req_gravity_torque_0 (gravity_torque[0]),
      .req_gravity_torque_1 (gravity_torque[1]),
      .req_gravity_torque_2 (gravity_torque[2]),
      .req_gravity_torque_3 (gravity_torque[3]),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_residual_0       (residual_0),
      .rsp_residual_1       (residual_1),
      .rsp_residual_2       (residual_2),
      .rsp_residual_3       (residual_3),
      .rsp_over_mask        (over_mask),
      .rsp_contact_joint    (contact_joint),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   momentum_observer_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_momentum       (momentum),
      .req_drive_torque   (drive_torque),
      .req_gravity_torque (gravity_torque),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_residual       ({residual_3, residual_2, residual_1, residual_0}),
      .rsp_over_mask      (over_mask),
      .rsp_contact_joint  (contact_joint),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .mismatches         (mismatches),
      .pending            (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic joint_vec_type all_joints(input logic [DATA_W-1:0] v);
      joint_vec_type r;
      for (int j = 0; j < JOINTS; j++) r[j] = v;
      return r;
   endfunction

   // mostly small Q16.16 values, some full range, some at the extremes
   function automatic logic [DATA_W-1:0] random_q16();
      case ($urandom_range(9))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(3))
               0: return Q_MAX;
               1: return Q_MIN;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return $urandom_range(32'h0007_ffff) - 32'h0004_0000;
      endcase
   endfunction

   function automatic joint_vec_type random_joints();
      joint_vec_type r;
      for (int j = 0; j < JOINTS; j++) r[j] = random_q16();
      return r;
   endfunction

   task automatic send_request(input joint_vec_type p, input joint_vec_type tau,
                               input joint_vec_type g);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      momentum <= p;
      drive_torque <= tau;
      gravity_torque <= g;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // drop valid and hold until every request has produced its result
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [DATA_W-1:0] dt, input logic [DATA_W-1:0] gain,
                            input logic [DATA_W-1:0] thr);
      wait_idle();
      write_reg(CSR_STEP_TIME, dt);
      write_reg(CSR_OBSERVER_GAIN, gain);
      write_reg(CSR_CONTACT_THRESHOLD, thr);
   endtask

   task automatic random_config();
      logic [DATA_W-1:0] dt, gain, thr;
      case ($urandom_range(3))
         0: dt = '0;
         1: dt = DT_MAX;
         2: dt = STEP_TIME_RST;
         default: dt = $urandom;
      endcase
      case ($urandom_range(4))
         0: gain = '0;
         1: gain = '1;
         2: gain = Q_ONE;
         3: gain = GAIN_RST;
         default: gain = $urandom_range(32'h0010_0000);
      endcase
      case ($urandom_range(4))
         0: thr = '0;
         1: thr = THR_MAX;
         2: thr = THR_RST;
         3: thr = $urandom;
         default: thr = $urandom_range(32'h0004_0000);
      endcase
      configure(dt, gain, thr);
   endtask

   initial begin
      joint_vec_type p;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // unit gain and frozen integral: the residual equals the momentum
      configure('0, Q_ONE, THRESH);
      send_request(all_joints(THRESH), '0, '0);
      send_request(all_joints(THRESH + 1), '0, '0);
      for (int j = 0; j < JOINTS; j++) begin
         p = '0;
         p[j] = THRESH + 1;
         send_request(p, '0, '0);
      end
      p = '0;
      p[0] = THRESH + 1;
      p[2] = THRESH + 1;
      send_request(p, '0, '0);
      send_request(all_joints(-(THRESH + 1)), '0, '0);

      configure('0, Q_ONE, '0);
      write_reg(CSR_UNUSED, $urandom);
      send_request(all_joints(32'd1), '0, '0);
      send_request('0, '0, '0);

      // default tuning, extreme inputs
      configure(STEP_TIME_RST, GAIN_RST, THR_RST);
      send_request('0, '0, '0);
      send_request(all_joints(Q_MAX), '0, '0);
      send_request(all_joints(Q_MIN), '0, '0);
      send_request('0, all_joints(Q_MAX), all_joints(Q_MIN));
      send_request('0, all_joints(Q_MIN), all_joints(Q_MAX));
      send_request({Q_ONE, {DATA_W{1'b1}}, Q_MAX, Q_MIN},
                   {Q_MIN, Q_MAX, Q_ONE, {DATA_W{1'b0}}}, random_joints());

      // largest step and gain drive the integral into saturation
      configure(DT_MAX, '1, THR_MAX);
      repeat (2) send_request(all_joints(Q_MAX), all_joints(Q_MAX), all_joints(Q_MIN));
      repeat (2) send_request(all_joints(Q_MIN), all_joints(Q_MIN), all_joints(Q_MAX));
      configure(DT_MAX, '0, '0);
      send_request(random_joints(), random_joints(), random_joints());

      for (int phase = 0; phase < PHASES; phase++) begin
         random_config();
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 55; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 55; end
            default: begin idle_pct = 10; stall_pct = 10; end
         endcase
         repeat (PHASE_ITEMS) send_request(random_joints(), random_joints(), random_joints());
      end

      wait_idle();
      idle_pct = 0;
      stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/mocol_pkg.sv
hdl/mocol_ctrl.sv
hdl/mocol_dpath.sv
hdl/momentum_observer_collision_isolate_core.sv
tb/momentum_observer_checker.sv
tb/testbench.sv
